@@ rtl/noise_channel_lfsr_envelope_unit_defines.svh @@
// Assertion macros used by the checker file of the noise voice.
// No dependencies; include by bare file name.
`ifndef NOISE_CHANNEL_LFSR_ENVELOPE_UNIT_DEFINES_SVH
`define NOISE_CHANNEL_LFSR_ENVELOPE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NCLE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("noise voice check failed");

// Next-cycle implication, disabled during reset.
`define NCLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("noise voice check failed");

`endif

@@ rtl/ncle_pkg.sv @@
// Package of the noise voice: command and register codes, config struct,
// period and length tables. No dependencies.
package ncle_pkg;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_QUARTER = 2'd1,
        CMD_HALF    = 2'd2,
        CMD_LOAD    = 2'd3
    } cmd_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_INDEX   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_MODE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONST_VOLUME   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_VOLUME_PERIOD  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_HALT_LOOP      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_ENABLE = 3'd5;

    localparam logic [3:0] ENV_FULL = 4'hf;

    typedef struct packed {
        logic [3:0] period_index;
        logic       short_mode;
        logic       constant_volume;
        logic [3:0] volume_or_env_period;
        logic       halt_loop;
        logic       channel_enable;
    } cfg_t;

    typedef struct packed {
        logic [3:0] sample;
        logic       length_active;
    } result_t;

    function automatic logic [11:0] noise_period(input logic [3:0] idx);
        logic [11:0] p;
        unique case (idx)
            4'd0:    p = 12'd4;
            4'd1:    p = 12'd8;
            4'd2:    p = 12'd16;
            4'd3:    p = 12'd32;
            4'd4:    p = 12'd64;
            4'd5:    p = 12'd96;
            4'd6:    p = 12'd128;
            4'd7:    p = 12'd160;
            4'd8:    p = 12'd202;
            4'd9:    p = 12'd254;
            4'd10:   p = 12'd380;
            4'd11:   p = 12'd508;
            4'd12:   p = 12'd762;
            4'd13:   p = 12'd1016;
            4'd14:   p = 12'd2034;
            default: p = 12'd4068;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] length_load(input logic [4:0] idx);
        logic [7:0] l;
        unique case (idx)
            5'd0:    l = 8'd10;
            5'd1:    l = 8'd254;
            5'd2:    l = 8'd20;
            5'd3:    l = 8'd2;
            5'd4:    l = 8'd40;
            5'd5:    l = 8'd4;
            5'd6:    l = 8'd80;
            5'd7:    l = 8'd6;
            5'd8:    l = 8'd160;
            5'd9:    l = 8'd8;
            5'd10:   l = 8'd60;
            5'd11:   l = 8'd10;
            5'd12:   l = 8'd14;
            5'd13:   l = 8'd12;
            5'd14:   l = 8'd26;
            5'd15:   l = 8'd14;
            5'd16:   l = 8'd12;
            5'd17:   l = 8'd16;
            5'd18:   l = 8'd24;
            5'd19:   l = 8'd18;
            5'd20:   l = 8'd48;
            5'd21:   l = 8'd20;
            5'd22:   l = 8'd96;
            5'd23:   l = 8'd22;
            5'd24:   l = 8'd192;
            5'd25:   l = 8'd24;
            5'd26:   l = 8'd72;
            5'd27:   l = 8'd26;
            5'd28:   l = 8'd16;
            5'd29:   l = 8'd28;
            5'd30:   l = 8'd32;
            default: l = 8'd30;
        endcase
        return l;
    endfunction

endpackage

@@ rtl/ncle_core.sv @@
// Voice state of the noise channel: LFSR, period divider, envelope, length.
// Depends on ncle_pkg. Result is taken from the state after the item.
module ncle_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [1:0]        cmd,
    input  logic [4:0]        length_index,
    input  ncle_pkg::cfg_t    cfg,
    output ncle_pkg::result_t result
);

    logic [14:0] lfsr_reg, lfsr_next;
    logic [11:0] period_count_reg, period_count_next;
    logic [3:0]  env_volume_reg, env_volume_next;
    logic [3:0]  env_divider_reg, env_divider_next;
    logic [7:0]  length_count_reg, length_count_next;

    ncle_pkg::cmd_t cmd_code;
    logic           env_clock;
    logic           tap;

    assign cmd_code = ncle_pkg::cmd_t'(cmd);
    assign tap      = cfg.short_mode ? lfsr_reg[6] : lfsr_reg[1];

    always_comb
    begin
        lfsr_next         = lfsr_reg;
        period_count_next = period_count_reg;
        env_volume_next   = env_volume_reg;
        env_divider_next  = env_divider_reg;
        length_count_next = length_count_reg;
        env_clock         = 1'b0;

        unique case (cmd_code)
            ncle_pkg::CMD_TICK:
            begin
                if (period_count_reg == 12'd1)
                begin
                    period_count_next = ncle_pkg::noise_period(cfg.period_index);
                    lfsr_next         = {lfsr_reg[0] ^ tap, lfsr_reg[14:1]};
                end
                else
                begin
                    period_count_next = period_count_reg - 12'd1;
                end
            end
            ncle_pkg::CMD_QUARTER:
            begin
                env_clock = 1'b1;
            end
            ncle_pkg::CMD_HALF:
            begin
                env_clock = 1'b1;
                if (cfg.channel_enable && (length_count_reg != 8'd0) && !cfg.halt_loop)
                begin
                    length_count_next = length_count_reg - 8'd1;
                end
            end
            ncle_pkg::CMD_LOAD:
            begin
                length_count_next = ncle_pkg::length_load(length_index);
                env_volume_next   = ncle_pkg::ENV_FULL;
                env_divider_next  = cfg.volume_or_env_period;
            end
            default:
            begin
            end
        endcase

        if (env_clock)
        begin
            priority if (env_divider_reg != 4'd0)
            begin
                env_divider_next = env_divider_reg - 4'd1;
            end
            else if (env_volume_reg != 4'd0)
            begin
                env_volume_next  = env_volume_reg - 4'd1;
                env_divider_next = cfg.volume_or_env_period;
            end
            else if (cfg.halt_loop)
            begin
                env_volume_next  = ncle_pkg::ENV_FULL;
                env_divider_next = cfg.volume_or_env_period;
            end
        end
    end

    // mute on LFSR bit 0 or an expired length, in both volume modes
    always_comb
    begin
        result.length_active = (length_count_next != 8'd0);
        if (lfsr_next[0] || (length_count_next == 8'd0))
        begin
            result.sample = 4'd0;
        end
        else if (cfg.constant_volume)
        begin
            result.sample = cfg.volume_or_env_period;
        end
        else
        begin
            result.sample = env_volume_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg         <= 15'd1;
            period_count_reg <= 12'd1;
            env_volume_reg   <= 4'd0;
            env_divider_reg  <= 4'd0;
            length_count_reg <= 8'd0;
        end
        else if (accept)
        begin
            lfsr_reg         <= lfsr_next;
            period_count_reg <= period_count_next;
            env_volume_reg   <= env_volume_next;
            env_divider_reg  <= env_divider_next;
            length_count_reg <= length_count_next;
        end
    end

endmodule

@@ rtl/noise_channel_lfsr_envelope_unit.sv @@
// Top level of the noise voice: config registers, voice core, output skid.
// Depends on ncle_pkg and ncle_core.
//
// Use: each input item (cmd, length_index) on in_valid/in_ready is one
// command: sample tick, quarter frame, half frame or length load. Each item
// yields exactly one result item (sample, length_active) on
// out_valid/out_ready, in order, taken from the voice state after that item.
// A result is registered into the output register when its item is accepted,
// or into the skid register if the receiver stalls. Throughput is one item per
// cycle while in_ready is high; the voice state update and output level logic
// sit between the state registers and the output register.
// When the receiver stalls, one more item is accepted and its result parks in
// a skid register; in_ready then drops until the skid drains.
// Configuration is written by cfg_we/cfg_index/cfg_data;
// indexes beyond the register list are ignored.
// Reset (rst_n low, asynchronous) sets LFSR to 1, the period count to 1,
// envelope and length to 0, all config registers to 0, and empties outputs.
module noise_channel_lfsr_envelope_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          cmd,
    input  logic [4:0]                          length_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [3:0]                          sample,
    output logic                                length_active,
    input  logic                                cfg_we,
    input  logic [ncle_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ncle_pkg::CFG_DATA_W-1:0]     cfg_data
);

    ncle_pkg::cfg_t    cfg_reg;
    ncle_pkg::result_t core_result;
    ncle_pkg::result_t out_reg;
    ncle_pkg::result_t skid_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic              accept;
    logic              pop;

    assign in_ready      = !skid_valid_reg;
    assign accept        = in_valid && in_ready;
    assign pop           = out_valid_reg && out_ready;
    assign out_valid     = out_valid_reg;
    assign sample        = out_reg.sample;
    assign length_active = out_reg.length_active;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ncle_pkg::CFG_PERIOD_INDEX:   cfg_reg.period_index         <= cfg_data;
                ncle_pkg::CFG_SHORT_MODE:     cfg_reg.short_mode           <= cfg_data[0];
                ncle_pkg::CFG_CONST_VOLUME:   cfg_reg.constant_volume      <= cfg_data[0];
                ncle_pkg::CFG_VOLUME_PERIOD:  cfg_reg.volume_or_env_period <= cfg_data;
                ncle_pkg::CFG_HALT_LOOP:      cfg_reg.halt_loop            <= cfg_data[0];
                ncle_pkg::CFG_CHANNEL_ENABLE: cfg_reg.channel_enable       <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    ncle_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .cmd          (cmd),
        .length_index (length_index),
        .cfg          (cfg_reg),
        .result       (core_result)
    );

    // output register plus one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (pop && skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (accept && out_valid_reg && !out_ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (pop && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
        else if (accept && out_valid_reg && !out_ready)
        begin
            skid_reg <= core_result;
        end
        else if (accept)
        begin
            out_reg <= core_result;
        end
    end

endmodule

@@ rtl/ncle_checker.sv @@
// Port-level checks of the noise voice, bound to the top level.
// Depends on ncle_pkg and noise_channel_lfsr_envelope_unit_defines.svh.
`include "noise_channel_lfsr_envelope_unit_defines.svh"

module ncle_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] cmd,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] sample,
    input logic       length_active
);

    `NCLE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `NCLE_ASSERT_SAME(a_mute_idle_length, clk, rst_n, out_valid && !length_active, sample == 4'd0)
    `NCLE_ASSERT_SAME(a_stall_full, clk, rst_n, !in_ready, out_valid)
    `NCLE_ASSERT_NEXT(a_load_active, clk, rst_n,
        in_valid && in_ready && (out_ready || !out_valid) && (cmd == ncle_pkg::CMD_LOAD),
        out_valid && length_active)

endmodule

bind noise_channel_lfsr_envelope_unit ncle_checker u_ncle_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sample        (sample),
    .length_active (length_active)
);

@@ tb/noise_channel_lfsr_envelope_unit_tb.sv @@
// Self-checking bench for the noise voice: a queued command driver, a result monitor
// and a cycle-free model of the voice state, all checked item by item.
// Depends on ncle_pkg and noise_channel_lfsr_envelope_unit.
module noise_channel_lfsr_envelope_unit_tb;

    localparam logic [ncle_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [ncle_pkg::CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int PHASE_ITEMS = 210;
    localparam int RAND_PHASES = 8;

    // Index 0 sits in the lowest slice.
    localparam logic [16*12-1:0] PERIOD_TAB = {
        12'd4068, 12'd2034, 12'd1016, 12'd762, 12'd508, 12'd380, 12'd254, 12'd202,
        12'd160, 12'd128, 12'd96, 12'd64, 12'd32, 12'd16, 12'd8, 12'd4
    };
    localparam logic [32*8-1:0] LENGTH_TAB = {
        8'd30, 8'd32, 8'd28, 8'd16, 8'd26, 8'd72, 8'd24, 8'd192,
        8'd22, 8'd96, 8'd20, 8'd48, 8'd18, 8'd24, 8'd16, 8'd12,
        8'd14, 8'd26, 8'd12, 8'd14, 8'd10, 8'd60, 8'd8, 8'd160,
        8'd6, 8'd80, 8'd4, 8'd40, 8'd2, 8'd20, 8'd254, 8'd10
    };

    typedef struct packed {
        ncle_pkg::cmd_t op;
        logic [4:0]     lidx;
    } voice_cmd_t;

    logic                             clk;
    logic                             rst_n = 1'b0;
    logic                             in_valid = 1'b0;
    logic                             in_ready;
    logic [1:0]                       cmd = ncle_pkg::CMD_TICK;
    logic [4:0]                       length_index = 5'd0;
    logic                             out_valid;
    logic                             out_ready = 1'b1;
    logic [3:0]                       sample;
    logic                             length_active;
    logic                             cfg_we = 1'b0;
    logic [ncle_pkg::CFG_INDEX_W-1:0] cfg_index = ncle_pkg::CFG_PERIOD_INDEX;
    logic [ncle_pkg::CFG_DATA_W-1:0]  cfg_data = 4'd0;

    voice_cmd_t        pending_cmds[$];
    ncle_pkg::result_t level_q[$];
    voice_cmd_t        next_cmd;
    ncle_pkg::result_t want;
    int                faults = 0;
    int                items_taken = 0;
    int                results_seen = 0;
    int                hold_left = 0;

    // Model state
    ncle_pkg::cfg_t voice_cfg = '0;
    logic [14:0]    m_lfsr = 15'd1;
    logic [11:0]    m_count = 12'd1;
    logic [3:0]     m_env_vol = 4'd0;
    logic [3:0]     m_env_div = 4'd0;
    logic [7:0]     m_len = 8'd0;

    noise_channel_lfsr_envelope_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .length_index  (length_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sample        (sample),
        .length_active (length_active),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clock_envelope();
        if (m_env_div != 4'd0)
            m_env_div = m_env_div - 4'd1;
        else if (m_env_vol != 4'd0)
        begin
            m_env_vol = m_env_vol - 4'd1;
            m_env_div = voice_cfg.volume_or_env_period;
        end
        else if (voice_cfg.halt_loop)
        begin
            m_env_vol = ncle_pkg::ENV_FULL;
            m_env_div = voice_cfg.volume_or_env_period;
        end
    endfunction

    // Apply one command to the model and return the level it leaves behind.
    function automatic ncle_pkg::result_t advance_voice(input ncle_pkg::cmd_t op,
                                                        input logic [4:0] lidx);
        ncle_pkg::result_t r;
        logic              tap;
        case (op)
            ncle_pkg::CMD_TICK:
                if (m_count == 12'd1)
                begin
                    m_count = PERIOD_TAB[voice_cfg.period_index * 12 +: 12];
                    tap = voice_cfg.short_mode ? m_lfsr[6] : m_lfsr[1];
                    m_lfsr = {m_lfsr[0] ^ tap, m_lfsr[14:1]};
                end
                else
                    m_count = m_count - 12'd1;
            ncle_pkg::CMD_QUARTER:
                clock_envelope();
            ncle_pkg::CMD_HALF:
            begin
                if (voice_cfg.channel_enable && m_len != 8'd0 && !voice_cfg.halt_loop)
                    m_len = m_len - 8'd1;
                clock_envelope();
            end
            default:
            begin
                m_len = LENGTH_TAB[lidx * 8 +: 8];
                m_env_vol = ncle_pkg::ENV_FULL;
                m_env_div = voice_cfg.volume_or_env_period;
            end
        endcase
        if (m_lfsr[0] || m_len == 8'd0)
            r.sample = 4'd0;
        else if (voice_cfg.constant_volume)
            r.sample = voice_cfg.volume_or_env_period;
        else
            r.sample = m_env_vol;
        r.length_active = (m_len != 8'd0);
        return r;
    endfunction

    // Driver: take the item on the handshake, then offer the next one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                level_q.push_back(advance_voice(ncle_pkg::cmd_t'(cmd), length_index));
                items_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_cmds.size() != 0 &&
                    ((items_taken >= 900 && items_taken < 1150) ||
                     $urandom_range(99) >= 13))
                begin
                    next_cmd = pending_cmds.pop_front();
                    in_valid <= 1'b1;
                    cmd <= next_cmd.op;
                    length_index <= next_cmd.lidx;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result item, then decide whether to stall.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (level_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got sample %0d active %0b",
                             $time, sample, length_active);
                    faults++;
                end
                else
                begin
                    want = level_q.pop_front();
                    if (sample !== want.sample)
                    begin
                        $display("%0t: sample expected %0d got %0d",
                                 $time, want.sample, sample);
                        faults++;
                    end
                    if (length_active !== want.length_active)
                    begin
                        $display("%0t: length_active expected %0b got %0b",
                                 $time, want.length_active, length_active);
                        faults++;
                    end
                end
                results_seen++;
                // Hold off long enough to back the voice up into its input.
                if (results_seen == 500 || results_seen == 1300)
                    hold_left = 80;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (results_seen >= 900 && results_seen < 1150)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 13);
        end
    end

    task automatic queue_cmd(input ncle_pkg::cmd_t op, input logic [4:0] lidx);
        voice_cmd_t c;
        c.op = op;
        c.lidx = lidx;
        pending_cmds.push_back(c);
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || in_valid || level_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_reg(input logic [ncle_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [3:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            ncle_pkg::CFG_PERIOD_INDEX:   voice_cfg.period_index = val;
            ncle_pkg::CFG_SHORT_MODE:     voice_cfg.short_mode = val[0];
            ncle_pkg::CFG_CONST_VOLUME:   voice_cfg.constant_volume = val[0];
            ncle_pkg::CFG_VOLUME_PERIOD:  voice_cfg.volume_or_env_period = val;
            ncle_pkg::CFG_HALT_LOOP:      voice_cfg.halt_loop = val[0];
            ncle_pkg::CFG_CHANNEL_ENABLE: voice_cfg.channel_enable = val[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all(input logic [3:0] period, input logic [3:0] short_m,
                           input logic [3:0] const_v, input logic [3:0] vol,
                           input logic [3:0] halt, input logic [3:0] enable);
        set_reg(ncle_pkg::CFG_PERIOD_INDEX, period);
        set_reg(ncle_pkg::CFG_SHORT_MODE, short_m);
        set_reg(ncle_pkg::CFG_CONST_VOLUME, const_v);
        set_reg(ncle_pkg::CFG_VOLUME_PERIOD, vol);
        set_reg(ncle_pkg::CFG_HALT_LOOP, halt);
        set_reg(ncle_pkg::CFG_CHANNEL_ENABLE, enable);
    endtask

    // Mostly ticks, so the LFSR keeps moving between frame events.
    task automatic queue_random_cmd();
        int             r;
        ncle_pkg::cmd_t op;
        r = $urandom_range(99);
        if (r < 55)
            op = ncle_pkg::CMD_TICK;
        else if (r < 75)
            op = ncle_pkg::CMD_QUARTER;
        else if (r < 90)
            op = ncle_pkg::CMD_HALF;
        else
            op = ncle_pkg::CMD_LOAD;
        queue_cmd(op, 5'($urandom_range(31)));
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers at reset: frame events on a silent voice, first shift,
        // length ignored by non-load commands, halves with the channel disabled.
        queue_cmd(ncle_pkg::CMD_QUARTER, 5'd31);
        queue_cmd(ncle_pkg::CMD_HALF, 5'd0);
        queue_cmd(ncle_pkg::CMD_TICK, 5'd31);
        queue_cmd(ncle_pkg::CMD_LOAD, 5'd1);
        queue_cmd(ncle_pkg::CMD_HALF, 5'd21);
        queue_cmd(ncle_pkg::CMD_QUARTER, 5'd10);
        repeat (4) queue_cmd(ncle_pkg::CMD_TICK, 5'd0);
        queue_cmd(ncle_pkg::CMD_LOAD, 5'd31);
        queue_cmd(ncle_pkg::CMD_LOAD, 5'd0);
        wait_drained();

        // Short mode, envelope output, run the length counter down to zero.
        set_all(4'd0, 4'd1, 4'd0, 4'd0, 4'd0, 4'd1);
        set_reg(CFG_SPARE_HI, 4'hf);
        queue_cmd(ncle_pkg::CMD_LOAD, 5'd3);
        repeat (3) queue_cmd(ncle_pkg::CMD_HALF, 5'd31);
        queue_cmd(ncle_pkg::CMD_TICK, 5'd0);
        wait_drained();

        // Constant volume with the halt flag holding the length.
        set_all(4'd2, 4'd0, 4'd1, 4'd9, 4'd1, 4'd1);
        queue_cmd(ncle_pkg::CMD_LOAD, 5'd9);
        repeat (2) queue_cmd(ncle_pkg::CMD_HALF, 5'd0);
        repeat (2) queue_cmd(ncle_pkg::CMD_TICK, 5'd0);
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            if (p == 0)
                set_all(4'd15, 4'd1, 4'd1, 4'd15, 4'd1, 4'd1);
            else if (p == 1)
                set_all(4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0);
            else
                set_all(($urandom_range(3) == 0) ? 4'($urandom_range(15))
                                                 : 4'($urandom_range(3)),
                        4'($urandom_range(15)),
                        4'($urandom_range(15)),
                        4'($urandom_range(15)),
                        {3'($urandom_range(7)), 1'($urandom_range(3) == 0)},
                        {3'($urandom_range(7)), 1'($urandom_range(3) != 0)});
            set_reg(($urandom_range(1) == 0) ? CFG_SPARE_LO : CFG_SPARE_HI,
                    4'($urandom_range(15)));
            repeat (PHASE_ITEMS) queue_random_cmd();
            wait_drained();
        end

        repeat (5) @(posedge clk);
        if (faults == 0 && level_q.size() == 0)
            $display("noise_channel_lfsr_envelope_unit_tb OK");
        else
            $display("noise_channel_lfsr_envelope_unit_tb NOT OK");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("noise_channel_lfsr_envelope_unit_tb NOT OK");
        $finish;
    end

endmodule
